// ----- rtl/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 2 * BYTE_W;

  localparam logic [BYTE_W-1:0] CH_NEWLINE       = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE     = 8'h08;
  localparam logic [BYTE_W-1:0] CH_BLANK         = 8'h20;
  localparam logic [BYTE_W-1:0] BLANK_ATTR_RESET = 8'h07;

  typedef enum logic [1:0] {
    CMD_PRINT      = 2'd0,
    CMD_SET_CURSOR = 2'd1,
    CMD_WRITE_CELL = 2'd2,
    CMD_READ_CELL  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_PUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clear;
    logic move;
    logic fill;
    logic capture;
    logic push;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scroll_needed;
    logic read_inside;
    logic clear_last;
    logic move_last;
    logic fill_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/tcw_in_if.sv -----
`default_nettype none

interface tcw_in_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [BYTE_W-1:0] char_code;
  logic [BYTE_W-1:0] attrib;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;

  modport source (output valid, cmd, char_code, attrib, col, row, input ready);
  modport sink   (input valid, cmd, char_code, attrib, col, row, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcw_out_if.sv -----
`default_nettype none

interface tcw_out_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [BYTE_W-1:0] cell_char;
  logic [BYTE_W-1:0] cell_attrib;
  logic              scrolled;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_attrib, scrolled,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_char, cell_attrib, scrolled,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/tcw_ram.sv -----
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/tcw_ctrl.sv -----
`default_nettype none

module tcw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tcw_pkg::dp_status_t status,
  output tcw_pkg::ctrl_cmd_t      ctrl
);
  import tcw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (status.scroll_needed) begin
            state_nxt = ST_SCROLL;
          end else if (status.read_inside) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_READ:   state_nxt = ST_PUSH;
      ST_SCROLL: begin
        if (status.move_last) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (status.fill_last) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    ctrl         = '0;
    ctrl.accept  = (state_r == ST_IDLE) && in_valid;
    ctrl.clear   = (state_r == ST_CLEAR);
    ctrl.move    = (state_r == ST_SCROLL);
    ctrl.fill    = (state_r == ST_FILL);
    ctrl.capture = (state_r == ST_READ);
    ctrl.push    = (state_r == ST_PUSH) && status.out_free;
  end

endmodule

`default_nettype wire

// ----- rtl/tcw_datapath.sv -----
`default_nettype none

module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [tcw_pkg::BYTE_W-1:0]  cfg_wdata,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [tcw_pkg::BYTE_W-1:0]  in_char_code,
  input  wire logic [tcw_pkg::BYTE_W-1:0]  in_attrib,
  input  wire logic [tcw_pkg::COL_W-1:0]   in_col,
  input  wire logic [tcw_pkg::ROW_W-1:0]   in_row,
  input  wire tcw_pkg::ctrl_cmd_t          ctrl,
  output tcw_pkg::dp_status_t              status,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [tcw_pkg::COL_W-1:0]        out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]        out_cursor_row,
  output logic [tcw_pkg::BYTE_W-1:0]       out_cell_char,
  output logic [tcw_pkg::BYTE_W-1:0]       out_cell_attrib,
  output logic                             out_scrolled
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [AW-1:0]    LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0]    LAST_MOVE  = AW'(CELLS - COLUMNS);
  localparam logic [COL_W:0]   COLS_LIM   = (COL_W+1)'(COLUMNS);
  localparam logic [ROW_W:0]   ROWS_LIM   = (ROW_W+1)'(ROWS);
  localparam logic [ROW_W-1:0] BOTTOM_ROW = ROW_W'(ROWS - 1);

  function automatic logic [AW-1:0] cell_idx(input logic [COL_W-1:0] x,
                                             input logic [ROW_W-1:0] y);
    cell_idx = AW'(int'(y) * COLUMNS + int'(x));
  endfunction

  logic [COL_W-1:0]  cursor_x_r, cursor_x_nxt;
  logic [ROW_W-1:0]  cursor_y_r, cursor_y_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] blank_attr_r;
  logic [BYTE_W-1:0] res_char_r, res_attr_r;
  logic              res_scr_r;
  logic              out_valid_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [BYTE_W-1:0] out_char_r, out_attr_r;
  logic              out_scr_r;

  cmd_t              cmd;
  logic              pos_ok;
  logic [COL_W:0]    x_inc;
  logic [ROW_W:0]    y_inc;
  logic [COL_W-1:0]  px;
  logic [ROW_W:0]    py;
  logic              print_wr;
  logic              will_scroll;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign cmd    = cmd_t'(in_cmd);
  assign pos_ok = ({1'b0, in_col} < COLS_LIM) && ({1'b0, in_row} < ROWS_LIM);
  assign x_inc  = {1'b0, cursor_x_r} + 1'b1;
  assign y_inc  = {1'b0, cursor_y_r} + 1'b1;

  // cursor motion of a print
  always_comb begin
    px       = cursor_x_r;
    py       = {1'b0, cursor_y_r};
    print_wr = 1'b0;
    case (in_char_code)
      CH_NEWLINE: begin
        px = '0;
        py = y_inc;
      end
      CH_BACKSPACE: begin
        if (cursor_x_r != '0) px = cursor_x_r - 1'b1;
      end
      default: begin
        print_wr = 1'b1;
        if (x_inc >= COLS_LIM) begin
          px = '0;
          py = y_inc;
        end else begin
          px = x_inc[COL_W-1:0];
        end
      end
    endcase
    will_scroll = (py >= ROWS_LIM);
  end

  always_comb begin
    status               = '0;
    status.scroll_needed = (cmd == CMD_PRINT) && will_scroll;
    status.read_inside   = (cmd == CMD_READ_CELL) && pos_ok;
    status.clear_last    = (cnt_r == LAST_CELL);
    status.move_last     = (cnt_r == LAST_MOVE);
    status.fill_last     = (cnt_r == LAST_CELL);
    status.out_free      = !out_valid_r || out_ready;
  end

  // write port: clear pass, item write, scroll move, bottom row fill
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    if (ctrl.clear) begin
      ram_we = 1'b1;
    end else if (ctrl.accept) begin
      ram_wdata = {in_attrib, in_char_code};
      if (cmd == CMD_PRINT && print_wr) begin
        ram_we    = 1'b1;
        ram_waddr = cell_idx(cursor_x_r, cursor_y_r);
      end else if (cmd == CMD_WRITE_CELL && pos_ok) begin
        ram_we    = 1'b1;
        ram_waddr = cell_idx(in_col, in_row);
      end
    end else if (ctrl.move) begin
      // data read one row below in the previous cycle
      ram_we    = (cnt_r != '0);
      ram_waddr = cnt_r - 1'b1;
      ram_wdata = ram_rdata;
    end else if (ctrl.fill) begin
      ram_we    = 1'b1;
      ram_wdata = {blank_attr_r, CH_BLANK};
    end
  end

  always_comb begin
    if (ctrl.move) begin
      ram_raddr = AW'((AW+1)'(cnt_r) + (AW+1)'(COLUMNS));
    end else begin
      ram_raddr = cell_idx(in_col, in_row);
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    if (ctrl.accept) begin
      case (cmd)
        CMD_PRINT: begin
          cursor_x_nxt = px;
          cursor_y_nxt = will_scroll ? BOTTOM_ROW : py[ROW_W-1:0];
        end
        CMD_SET_CURSOR: begin
          if (pos_ok) begin
            cursor_x_nxt = in_col;
            cursor_y_nxt = in_row;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.accept) begin
      cnt_nxt = '0;
    end else if (ctrl.clear || ctrl.fill) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctrl.move && !status.move_last) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
      cnt_r        <= '0;
      blank_attr_r <= BLANK_ATTR_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      cnt_r      <= cnt_nxt;
      if (cfg_we) blank_attr_r <= cfg_wdata;
      if (ctrl.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      res_char_r <= '0;
      res_attr_r <= '0;
      res_scr_r  <= status.scroll_needed;
    end else if (ctrl.capture) begin
      res_char_r <= ram_rdata[BYTE_W-1:0];
      res_attr_r <= ram_rdata[CELL_W-1:BYTE_W];
    end
    if (ctrl.push) begin
      out_col_r  <= cursor_x_r;
      out_row_r  <= cursor_y_r;
      out_char_r <= res_char_r;
      out_attr_r <= res_attr_r;
      out_scr_r  <= res_scr_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cursor_col  = out_col_r;
  assign out_cursor_row  = out_row_r;
  assign out_cell_char   = out_char_r;
  assign out_cell_attrib = out_attr_r;
  assign out_scrolled    = out_scr_r;

endmodule

`default_nettype wire

// ----- rtl/text_console_writer.sv -----
// text console writer: a character grid of COLUMNS x ROWS cells (attribute byte over
// character byte) with a cursor, kept in one single-port-write ram
// in_ch carries one command word: print at cursor, set cursor, write cell, read cell
// out_ch returns one word per command: cursor after it, the cell read (zero unless a read
// in range) and a flag when the grid scrolled
// cfg_we / cfg_wdata load the blank attribute used for rows opened by a scroll (reset 7)
// reset: cursor to 0,0, then a clearing pass zeroes the grid one cell a cycle,
// with in_ready low; config writes are taken during it
// each word: accept in idle, then hand-off to the output register, with no new word taken
// in between; a read in range adds a wait state for the registered ram read
// a print that moves past the last row walks the grid through the ram, one cell a cycle,
// first moving the rows up one row, then filling the new bottom row
// the result is loaded into the output register at the hand-off, after any read or scroll
// the output register holds its word while out_ch.ready is low; the next input word is
// still accepted and worked, and its result waits in the engine until the register frees
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  tcw_in_if.sink                          in_ch,
  tcw_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [tcw_pkg::BYTE_W-1:0] cfg_wdata
);
  import tcw_pkg::*;

  ctrl_cmd_t  ctrl;     // per-cycle commands to the datapath
  dp_status_t status;   // decode of the input word, sweep counter flags and output register free

  // sequencer: clear pass, idle, read wait, scroll move, bottom fill, result hand-off
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // cursor, grid ram, sweep counter and output register
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_ch.cmd),
    .in_char_code    (in_ch.char_code),
    .in_attrib       (in_ch.attrib),
    .in_col          (in_ch.col),
    .in_row          (in_ch.row),
    .ctrl            (ctrl),
    .status          (status),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_cursor_col  (out_ch.cursor_col),
    .out_cursor_row  (out_ch.cursor_row),
    .out_cell_char   (out_ch.cell_char),
    .out_cell_attrib (out_ch.cell_attrib),
    .out_scrolled    (out_ch.scrolled)
  );

endmodule

`default_nettype wire

// ----- rtl/tcw_checker.sv -----
`default_nettype none

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [tcw_pkg::COL_W-1:0]  out_cursor_col,
  input wire logic [tcw_pkg::ROW_W-1:0]  out_cursor_row,
  input wire logic                       out_scrolled
);
  import tcw_pkg::*;

  // one word in flight: no accept in the cycle right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // cursor reported inside the grid
  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_col) < COLUMNS) && (int'(out_cursor_row) < ROWS))
    else $error("cursor outside grid");

  // a scroll always leaves the cursor on the bottom row
  a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scrolled) |-> (int'(out_cursor_row) == ROWS - 1))
    else $error("scroll without cursor on bottom row");

  // nothing to deliver straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_cursor_col (out_ch.cursor_col),
  .out_cursor_row (out_ch.cursor_row),
  .out_scrolled   (out_ch.scrolled)
);

`default_nettype wire
